// ----- sv/gbmcpa_pkg.sv -----
// Package for the GBM call payoff accumulator.
// Holds the sequencer states, register indexes, fixed-point constants and the
// request type of the shared multiplier; it depends on nothing else.
package gbmcpa_pkg;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Slightly below 2^63 / LN2_Q32, so the quotient estimate is never too large.
  localparam logic [31:0] LN2_RECIP = 32'd3098160000;

  localparam int MUL_W = 33;

  typedef logic [2:0] cfg_addr_t;

  localparam cfg_addr_t CFG_INIT_PRICE = 3'd0;
  localparam cfg_addr_t CFG_STRIKE     = 3'd1;
  localparam cfg_addr_t CFG_VOLATILITY = 3'd2;
  localparam cfg_addr_t CFG_DAILY_RATE = 3'd3;
  localparam cfg_addr_t CFG_MATURITY   = 3'd4;
  localparam cfg_addr_t CFG_STEP_DAYS  = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HALF,
    ST_RH,
    ST_DRIFT,
    ST_SQRT,
    ST_SD,
    ST_SDREG,
    ST_DLO,
    ST_DHI,
    ST_DSUM,
    ST_EINIT,
    ST_KDIV,
    ST_KREM,
    ST_KFIX,
    ST_TMUL,
    ST_TLOAD,
    ST_TDIV,
    ST_TACC,
    ST_SCALE,
    ST_SHIFT,
    ST_DISC,
    ST_DISCX,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             en;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

endpackage

// ----- sv/gbm_call_payoff_accumulator.sv -----
// Top level of the GBM call payoff accumulator: sequencer, datapath and result register.
// Uses gbmcpa_pkg and the shared multiplier gbmcpa_mul.
//
//   channel   signals                                        direction
//   input     in_valid, in_ready, normal_sample              beat in
//   output    out_valid, out_ready, discounted_payoff,       beat out
//             payoff_sum, paths_done, sum_saturated
//   config    cfg_we, cfg_addr, cfg_data                     write only
//
// An ordinary step runs a square root, a quotient by ln 2 from two multiplies and one
// correction, and twelve series terms, all on the one multiplier and the sequencer.
// A path-ending beat adds a second exponential for the discount. A finished result
// waits in the output register; the next path end stalls only if that result has not
// yet been taken.
// Reset is synchronous and restores the register defaults and empty sum and count.
module gbm_call_payoff_accumulator #(
  parameter int SUM_BITS   = 48,
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  gbmcpa_pkg::cfg_addr_t cfg_addr,
  input  logic [31:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    normal_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           discounted_payoff,
  output logic [SUM_BITS-1:0]   payoff_sum,
  output logic [COUNT_BITS-1:0] paths_done,
  output logic                  sum_saturated
);
  import gbmcpa_pkg::*;

  state_t state, state_next;

  logic [31:0] init_price, strike, daily_rate;
  logic [23:0] volatility;
  logic [11:0] maturity, step_days;

  logic [31:0]           path_price;
  logic [11:0]           day_index;
  logic [SUM_BITS-1:0]   sum_reg;
  logic [COUNT_BITS-1:0] count;

  logic               zneg, last, rh_neg, xneg, phase;
  logic [15:0]        zmag, q;
  logic [11:0]        dt;
  logic [31:0]        price_in, rh_mag, rem, f, dq, pval, disc_reg;
  logic signed [46:0] acc;
  logic [45:0]        sq_v, sq_res, sq_bit;
  logic [4:0]         cnt;
  logic [3:0]         idx, drem;
  logic [37:0]        sd;
  logic [47:0]        lo;
  logic signed [16:0] k;
  logic [32:0]        term;
  logic [33:0]        esum;

  mul_req_t    mreq;
  logic [65:0] prod;

  gbmcpa_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  logic [11:0] ts, remain, dt_in;
  logic        last_in;
  logic [45:0] sq_try;
  logic [32:0] rh_diff;
  logic [45:0] rdiff;
  logic        kge;
  logic [46:0] acc_abs;
  logic [53:0] dfull;
  logic [41:0] dmag;
  logic [31:0] dq_next, scaled, payoff;
  logic [3:0]  drem_next;
  logic [63:0] mshift;
  logic [5:0]  shv;
  logic [16:0] qx;
  logic [SUM_BITS:0] sum_add;
  logic        fin_load;

  always_comb begin
    ts = (step_days == 12'd0) ? 12'd1 : step_days;
    remain = maturity - day_index;
    if (day_index >= maturity) begin
      dt_in = 12'd0;
      last_in = 1'b1;
    end else if (ts < remain) begin
      dt_in = ts;
      last_in = 1'b0;
    end else begin
      dt_in = remain;
      last_in = 1'b1;
    end
  end

  always_comb begin
    logic [4:0] t;
    logic [31:0] d;
    logic [3:0] r;
    d = dq;
    r = drem;
    for (int j = 0; j < 8; j++) begin
      t = {r, d[31]};
      if (t >= {1'b0, idx}) begin
        d = {d[30:0], 1'b1};
        r = 4'(t - {1'b0, idx});
      end else begin
        d = {d[30:0], 1'b0};
        r = t[3:0];
      end
    end
    dq_next = d;
    drem_next = r;
  end

  assign sq_try   = sq_res + sq_bit;
  assign rh_diff  = {1'b0, daily_rate} - {2'b0, prod[47:17]};
  assign acc_abs  = acc[46] ? 47'(-acc) : 47'(acc);
  assign rdiff    = acc_abs[45:0] - prod[45:0];
  assign kge      = rdiff >= {14'b0, LN2_Q32};
  assign dfull    = {6'b0, lo} + {prod[21:0], 32'b0};
  assign dmag     = dfull[53:12];
  assign qx       = {1'b0, q};
  assign payoff   = (scaled > strike) ? scaled - strike : 32'd0;
  assign sum_add  = {1'b0, sum_reg} + (SUM_BITS+1)'(disc_reg);
  assign fin_load = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    shv = 6'(17'sd31 - k);
    mshift = prod[63:0] >> shv;
    if (prod[63:0] == 64'd0) begin
      scaled = 32'd0;
    end else if (k > 17'sd31) begin
      scaled = 32'hFFFF_FFFF;
    end else if (k < -17'sd32) begin
      scaled = 32'd0;
    end else if (|mshift[63:32]) begin
      scaled = 32'hFFFF_FFFF;
    end else begin
      scaled = mshift[31:0];
    end
  end

  always_comb begin
    mreq.en = 1'b1;
    mreq.a  = '0;
    mreq.b  = '0;
    unique case (state)
      ST_HALF: begin
        mreq.a = MUL_W'(volatility);
        mreq.b = MUL_W'(volatility);
      end
      ST_DRIFT: begin
        mreq.a = MUL_W'(rh_mag);
        mreq.b = MUL_W'(dt);
      end
      ST_SD: begin
        mreq.a = MUL_W'(volatility);
        mreq.b = MUL_W'(sq_res[21:0]);
      end
      ST_DLO: begin
        mreq.a = MUL_W'(sd[31:0]);
        mreq.b = MUL_W'(zmag);
      end
      ST_DHI: begin
        mreq.a = MUL_W'(sd[37:32]);
        mreq.b = MUL_W'(zmag);
      end
      ST_EINIT: begin
        mreq.a = MUL_W'(acc_abs[45:13]);
        mreq.b = MUL_W'(LN2_RECIP);
      end
      ST_KDIV: begin
        mreq.a = MUL_W'(prod[65:50]);
        mreq.b = MUL_W'(LN2_Q32);
      end
      ST_TMUL: begin
        mreq.a = term;
        mreq.b = MUL_W'(f);
      end
      ST_SCALE: begin
        mreq.a = MUL_W'(pval);
        mreq.b = MUL_W'(esum[32:1]);
      end
      ST_DISC: begin
        mreq.a = MUL_W'(daily_rate);
        mreq.b = MUL_W'(maturity);
      end
      default: begin
        mreq.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_HALF;
      end
      ST_HALF:  state_next = ST_RH;
      ST_RH:    state_next = ST_DRIFT;
      ST_DRIFT: state_next = ST_SQRT;
      ST_SQRT:  if (cnt == 5'd22) state_next = ST_SD;
      ST_SD:    state_next = ST_SDREG;
      ST_SDREG: state_next = ST_DLO;
      ST_DLO:   state_next = ST_DHI;
      ST_DHI:   state_next = ST_DSUM;
      ST_DSUM:  state_next = ST_EINIT;
      ST_EINIT: state_next = ST_KDIV;
      ST_KDIV:  state_next = ST_KREM;
      ST_KREM:  state_next = ST_KFIX;
      ST_KFIX:  state_next = ST_TMUL;
      ST_TMUL:  state_next = ST_TLOAD;
      ST_TLOAD: state_next = ST_TDIV;
      ST_TDIV:  if (cnt == 5'd3) state_next = ST_TACC;
      ST_TACC:  state_next = (idx == 4'd12) ? ST_SCALE : ST_TMUL;
      ST_SCALE: state_next = ST_SHIFT;
      ST_SHIFT: begin
        if (phase) state_next = ST_FIN;
        else if (last) state_next = ST_DISC;
        else state_next = ST_IDLE;
      end
      ST_DISC:  state_next = ST_DISCX;
      ST_DISCX: state_next = ST_EINIT;
      ST_FIN:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_price <= 32'd6553600;
      strike     <= 32'd6553600;
      volatility <= 24'd335544;
      daily_rate <= 32'd169591;
      maturity   <= 12'd252;
      step_days  <= 12'd252;
      path_price <= 32'd6553600;
      day_index  <= 12'd0;
      sum_reg    <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_INIT_PRICE: init_price <= cfg_data;
          CFG_STRIKE:     strike <= cfg_data;
          CFG_VOLATILITY: volatility <= cfg_data[23:0];
          CFG_DAILY_RATE: daily_rate <= cfg_data;
          CFG_MATURITY:   maturity <= cfg_data[11:0];
          CFG_STEP_DAYS:  step_days <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (state == ST_SHIFT && !phase && !last) begin
        path_price <= scaled;
        day_index  <= day_index + dt;
      end
      if (fin_load) begin
        path_price <= init_price;
        day_index  <= 12'd0;
        sum_reg    <= sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];
        if (!(&count)) count <= count + COUNT_BITS'(1);
        out_valid  <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      discounted_payoff <= disc_reg;
      payoff_sum <= sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];
      paths_done <= (&count) ? count : count + COUNT_BITS'(1);
      sum_saturated <= sum_add[SUM_BITS] || (&sum_add[SUM_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        zneg     <= normal_sample[15];
        zmag     <= normal_sample[15] ? 16'(-normal_sample) : 16'(normal_sample);
        dt       <= dt_in;
        last     <= last_in;
        price_in <= (day_index == 12'd0) ? init_price : path_price;
      end
      ST_HALF: begin
        sq_v   <= {2'b0, dt, 32'b0};
        sq_res <= '0;
        sq_bit <= 46'd1 << 44;
        cnt    <= '0;
      end
      ST_RH: begin
        rh_neg <= rh_diff[32];
        rh_mag <= rh_diff[32] ? 32'(-rh_diff) : rh_diff[31:0];
      end
      ST_SQRT: begin
        if (sq_v >= sq_try) begin
          sq_v   <= sq_v - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        cnt    <= cnt + 5'd1;
      end
      ST_SD: begin
        acc <= rh_neg ? -47'(prod[43:0]) : 47'(prod[43:0]);
      end
      ST_SDREG: sd <= prod[45:8];
      ST_DHI:   lo <= prod[47:0];
      ST_DSUM: begin
        acc   <= zneg ? acc - 47'(dmag) : acc + 47'(dmag);
        pval  <= price_in;
        phase <= 1'b0;
      end
      ST_EINIT: begin
        xneg <= acc[46];
      end
      ST_KDIV: begin
        q <= prod[65:50];
      end
      ST_KREM: begin
        rem <= kge ? 32'(rdiff - {14'b0, LN2_Q32}) : rdiff[31:0];
        q   <= q + {15'b0, kge};
      end
      ST_KFIX: begin
        if (!xneg) begin
          k <= qx;
          f <= rem;
        end else if (rem == 32'd0) begin
          k <= -qx;
          f <= 32'd0;
        end else begin
          k <= -(qx + 17'd1);
          f <= LN2_Q32 - rem;
        end
        term <= 33'h1_0000_0000;
        esum <= 34'h1_0000_0000;
        idx  <= 4'd1;
      end
      ST_TLOAD: begin
        dq   <= prod[63:32];
        drem <= '0;
        cnt  <= '0;
      end
      ST_TDIV: begin
        dq   <= dq_next;
        drem <= drem_next;
        cnt  <= cnt + 5'd1;
      end
      ST_TACC: begin
        term <= 33'(dq);
        esum <= esum + 34'(dq);
        idx  <= idx + 4'd1;
      end
      ST_SHIFT: begin
        if (phase) disc_reg <= scaled;
        else pval <= payoff;
      end
      ST_DISCX: begin
        acc   <= -47'(prod[43:0]);
        phase <= 1'b1;
      end
      default: ;
    endcase
  end

  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sum_saturated == (&payoff_sum)))
    else $error("sum_saturated disagrees with payoff_sum");

  a_kdiv_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KFIX) |-> (rem < LN2_Q32))
    else $error("ln2 quotient remainder out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a step is in progress");

  a_count: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (paths_done != '0))
    else $error("result shown with no counted path");

endmodule

// ----- sv/gbmcpa_mul.sv -----
// Shared unsigned multiplier of the GBM call payoff accumulator.
// The product is registered and holds until the next request.
// Depends on gbmcpa_pkg.
module gbmcpa_mul (
  input  logic                  clk,
  input  gbmcpa_pkg::mul_req_t  req,
  output logic [2*gbmcpa_pkg::MUL_W-1:0] prod
);
  import gbmcpa_pkg::*;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= (2*MUL_W)'(req.a) * (2*MUL_W)'(req.b);
    end
  end

endmodule
